@@ rtl/ucng_pkg.sv @@
// ----------------------------------------------------------------------------
// ucng_pkg
// Types, constants and byte classification helpers shared by the UTF-8
// character n-gram window.
// ----------------------------------------------------------------------------
package ucng_pkg;

	localparam int MAX_GRAM_DEFAULT = 8;
	localparam int GRAM_LIMIT       = 8;
	localparam int QUEUE_DEPTH      = 4;
	localparam int QUEUE_PTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [3:0] GRAM_SIZE_RESET = 4'd3;
	localparam logic [7:0] SPACE_BYTE      = 8'h20;
	localparam logic [7:0] CONT_MASK       = 8'b1100_0000;
	localparam logic [7:0] CONT_BITS       = 8'b1000_0000;
	localparam logic [7:0] LEAD2_MASK      = 8'b1110_0000;
	localparam logic [7:0] LEAD3_MASK      = 8'b1111_0000;
	localparam logic [7:0] LEAD4_MASK      = 8'b1111_1000;

	// One entry handed from the front end to the window logic: a character, an end-of-text clear, or both.
	typedef struct packed {
		logic        has_char;
		logic        clear;
		logic [2:0]  len;
		logic [31:0] value;
	} char_entry_t;

	typedef enum logic {
		FRONT_BYTE,
		FRONT_TAIL
	} front_state_t;

	typedef enum logic {
		BACK_FETCH,
		BACK_EMIT
	} back_state_t;

	function automatic logic [2:0] lead_length(input logic [7:0] b);
		logic [2:0] len;
		len = 3'd1;
		if ((b & CONT_BITS) == 8'h00) begin
			len = 3'd1;
		end else if ((b & LEAD2_MASK) == CONT_MASK) begin
			len = 3'd2;
		end else if ((b & LEAD3_MASK) == LEAD2_MASK) begin
			len = 3'd3;
		end else if ((b & LEAD4_MASK) == LEAD3_MASK) begin
			len = 3'd4;
		end
		return len;
	endfunction

	function automatic logic is_cont(input logic [7:0] b);
		return (b & CONT_MASK) == CONT_BITS;
	endfunction

	function automatic logic is_ws(input logic [7:0] b);
		return b inside {SPACE_BYTE, [8'h09:8'h0D]};
	endfunction

endpackage

@@ rtl/ucng_queue.sv @@
// ----------------------------------------------------------------------------
// ucng_queue
// Small first-in first-out buffer of character entries between the byte
// front end and the window logic.
// ----------------------------------------------------------------------------
module ucng_queue import ucng_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  char_entry_t wr_data,
	output logic        q_full,
	input  logic        rd_en,
	output char_entry_t rd_data,
	output logic        q_empty
);

	char_entry_t                entries_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0]     wr_ptr_q;
	logic [QUEUE_PTR_W-1:0]     rd_ptr_q;
	logic [QUEUE_CNT_W-1:0]     count_q;

	assign q_full  = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign q_empty = (count_q == '0);
	assign rd_data = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entries_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/ucng_front.sv @@
// ----------------------------------------------------------------------------
// ucng_front
// Byte front end: assembles UTF-8 characters, collapses whitespace, drops
// malformed characters and replays the trailing bytes of a character cut off
// by the end of the text. Each kept character becomes one queue entry.
// ----------------------------------------------------------------------------
module ucng_front import ucng_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        end_of_text,
	input  logic        q_full,
	output logic        ent_push,
	output char_entry_t ent
);

	front_state_t state_q, state_d;
	logic [31:0]  part_q, part_d;
	logic [2:0]   have_q, have_d;
	logic [2:0]   need_q, need_d;
	logic         any_q, any_d;
	logic         prev_sp_q, prev_sp_d;
	logic [7:0]   tb0_q, tb0_d;
	logic [7:0]   tb1_q, tb1_d;
	logic         tail_two_q, tail_two_d;
	logic         tail_i_q, tail_i_d;

	logic         accept;

	assign full   = (state_q != FRONT_BYTE) || q_full;
	assign accept = push && !full;

	always_comb begin
		logic [2:0]  len;
		logic [2:0]  have_n;
		logic [31:0] merged;
		logic        ok;
		logic        kk;
		logic [31:0] kv;
		logic [2:0]  kl;
		logic [7:0]  c;
		logic        done;
		logic        step2;

		len    = 3'd1;
		have_n = 3'd0;
		merged = '0;
		ok     = 1'b0;
		kk     = 1'b0;
		kv     = '0;
		kl     = 3'd1;
		c      = '0;
		done   = 1'b0;
		step2  = 1'b0;

		state_d    = state_q;
		part_d     = part_q;
		have_d     = have_q;
		need_d     = need_q;
		any_d      = any_q;
		prev_sp_d  = prev_sp_q;
		tb0_d      = tb0_q;
		tb1_d      = tb1_q;
		tail_two_d = tail_two_q;
		tail_i_d   = tail_i_q;
		ent_push   = 1'b0;
		ent        = '0;

		case (state_q)
			FRONT_BYTE: begin
				if (accept) begin
					if (need_q == 3'd0) begin
						len = lead_length(data_byte);
						if (len == 3'd1) begin
							if (is_ws(data_byte)) begin
								kk = any_q && !prev_sp_q;
								kv = 32'(SPACE_BYTE);
							end else begin
								kk = 1'b1;
								kv = 32'(data_byte);
							end
						end else begin
							part_d = 32'(data_byte);
							have_d = 3'd1;
							need_d = len;
						end
					end else begin
						merged = part_q | (32'(data_byte) << {have_q[1:0], 3'b000});
						have_n = have_q + 3'd1;
						if (have_n >= need_q) begin
							ok = (need_q <= 3'd1 || is_cont(merged[15:8]))
								&& (need_q <= 3'd2 || is_cont(merged[23:16]))
								&& (need_q <= 3'd3 || is_cont(merged[31:24]));
							kk     = ok;
							kv     = merged;
							kl     = need_q;
							part_d = '0;
							have_d = 3'd0;
							need_d = 3'd0;
						end else begin
							part_d = merged;
							have_d = have_n;
						end
					end

					if (kk) begin
						ent.has_char = 1'b1;
						ent.value    = kv;
						ent.len      = kl;
						ent_push     = 1'b1;
						any_d        = 1'b1;
						prev_sp_d    = (kl == 3'd1) && (kv == 32'(SPACE_BYTE));
					end

					if (end_of_text) begin
						part_d = '0;
						have_d = 3'd0;
						need_d = 3'd0;
						if (need_q != 3'd0 && have_n < need_q) begin
							// The lead byte is dropped; its followers are replayed.
							tb0_d      = merged[15:8];
							tb1_d      = merged[23:16];
							tail_two_d = (have_n == 3'd3);
							tail_i_d   = 1'b0;
							state_d    = FRONT_TAIL;
						end else begin
							ent.clear = 1'b1;
							ent_push  = 1'b1;
							any_d     = 1'b0;
							prev_sp_d = 1'b0;
						end
					end
				end
			end
			FRONT_TAIL: begin
				if (!q_full) begin
					c   = tail_i_q ? tb1_q : tb0_q;
					len = lead_length(c);
					if (len == 3'd1) begin
						if (is_ws(c)) begin
							kk = any_q && !prev_sp_q;
							kv = 32'(SPACE_BYTE);
						end else begin
							kk = 1'b1;
							kv = 32'(c);
						end
					end else if (len == 3'd2 && !tail_i_q && tail_two_q) begin
						step2 = 1'b1;
						kk    = is_cont(tb1_q);
						kv    = {16'h0000, tb1_q, tb0_q};
						kl    = 3'd2;
					end
					done = step2 || tail_i_q || !tail_two_q;

					ent.has_char = kk;
					ent.value    = kv;
					ent.len      = kl;
					ent.clear    = done;
					ent_push     = 1'b1;
					if (kk) begin
						any_d     = 1'b1;
						prev_sp_d = (kl == 3'd1) && (kv == 32'(SPACE_BYTE));
					end
					if (done) begin
						any_d     = 1'b0;
						prev_sp_d = 1'b0;
						state_d   = FRONT_BYTE;
					end else begin
						tail_i_d = 1'b1;
					end
				end
			end
			default: begin
				state_d = FRONT_BYTE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= FRONT_BYTE;
			part_q     <= '0;
			have_q     <= '0;
			need_q     <= '0;
			any_q      <= 1'b0;
			prev_sp_q  <= 1'b0;
			tail_two_q <= 1'b0;
			tail_i_q   <= 1'b0;
		end else begin
			state_q    <= state_d;
			part_q     <= part_d;
			have_q     <= have_d;
			need_q     <= need_d;
			any_q      <= any_d;
			prev_sp_q  <= prev_sp_d;
			tail_two_q <= tail_two_d;
			tail_i_q   <= tail_i_d;
		end
	end

	always_ff @(posedge clk) begin
		tb0_q <= tb0_d;
		tb1_q <= tb1_d;
	end

endmodule

@@ rtl/ucng_back.sv @@
// ----------------------------------------------------------------------------
// ucng_back
// Window logic: enters each character into a ring of the latest MAX_GRAM
// characters and streams the newest n-gram out through an output register.
// ----------------------------------------------------------------------------
module ucng_back import ucng_pkg::*; #(
	parameter int MAX_GRAM = MAX_GRAM_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [3:0]  gram_size,
	input  logic        q_empty,
	input  char_entry_t q_data,
	output logic        q_pop,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] char_value,
	output logic [2:0]  char_bytes,
	output logic [2:0]  position_in_gram,
	output logic        last_of_gram
);

	localparam int HW = (MAX_GRAM > 1) ? $clog2(MAX_GRAM) : 1;
	localparam int FW = $clog2(MAX_GRAM + 1);

	back_state_t   state_q;
	logic [31:0]   ring_val_q [MAX_GRAM];
	logic [2:0]    ring_len_q [MAX_GRAM];
	logic [HW-1:0] head_q;
	logic [FW-1:0] fill_q;
	logic [HW-1:0] rd_q;
	logic [3:0]    g_q;
	logic [2:0]    p_q;
	logic          clr_q;
	logic          out_v_q;

	logic [3:0]    g_eff;
	logic [HW-1:0] head_n;
	logic [FW-1:0] fill_n;
	logic [4:0]    start_slot;
	logic          load;
	logic          is_last;

	// Out-of-range sizes: zero acts as one, and the size is capped by the ring and by GRAM_LIMIT.
	always_comb begin
		g_eff = (gram_size == 4'd0) ? 4'd1 : gram_size;
		if ({1'b0, g_eff} > 5'(MAX_GRAM)) begin
			g_eff = 4'(MAX_GRAM);
		end
		if (g_eff > 4'(GRAM_LIMIT)) begin
			g_eff = 4'(GRAM_LIMIT);
		end
	end

	assign head_n = (head_q == HW'(MAX_GRAM - 1)) ? '0 : head_q + 1'b1;
	assign fill_n = (fill_q < FW'(MAX_GRAM)) ? fill_q + 1'b1 : fill_q;

	always_comb begin
		if (5'(head_n) >= 5'(g_eff)) begin
			start_slot = 5'(head_n) - 5'(g_eff);
		end else begin
			start_slot = 5'(head_n) + 5'(MAX_GRAM) - 5'(g_eff);
		end
	end

	assign q_pop   = (state_q == BACK_FETCH) && !q_empty;
	assign load    = (state_q == BACK_EMIT) && (!out_v_q || pop);
	assign is_last = ({1'b0, p_q} == g_q - 4'd1);
	assign empty   = !out_v_q;

	always_ff @(posedge clk) begin
		if (q_pop && q_data.has_char) begin
			ring_val_q[head_q] <= q_data.value;
			ring_len_q[head_q] <= q_data.len;
		end
		if (load) begin
			char_value       <= ring_val_q[rd_q];
			char_bytes       <= ring_len_q[rd_q];
			position_in_gram <= p_q;
			last_of_gram     <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BACK_FETCH;
			head_q  <= '0;
			fill_q  <= '0;
			rd_q    <= '0;
			g_q     <= '0;
			p_q     <= '0;
			clr_q   <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			case (state_q)
				BACK_FETCH: begin
					if (q_pop) begin
						if (q_data.has_char && (5'(fill_n) >= 5'(g_eff))) begin
							head_q  <= head_n;
							fill_q  <= fill_n;
							state_q <= BACK_EMIT;
							rd_q    <= HW'(start_slot);
							g_q     <= g_eff;
							p_q     <= '0;
							clr_q   <= q_data.clear;
						end else if (q_data.clear) begin
							head_q <= '0;
							fill_q <= '0;
						end else if (q_data.has_char) begin
							head_q <= head_n;
							fill_q <= fill_n;
						end
					end
				end
				BACK_EMIT: begin
					if (load) begin
						rd_q <= (rd_q == HW'(MAX_GRAM - 1)) ? '0 : rd_q + 1'b1;
						p_q  <= p_q + 1'b1;
						if (is_last) begin
							state_q <= BACK_FETCH;
							if (clr_q) begin
								head_q <= '0;
								fill_q <= '0;
							end
						end
					end
				end
				default: begin
					state_q <= BACK_FETCH;
				end
			endcase

			if (load) begin
				out_v_q <= 1'b1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/utf8_char_ngram_window.sv @@
// ----------------------------------------------------------------------------
// utf8_char_ngram_window
// Streams UTF-8 text byte by byte and emits character n-grams.
// ----------------------------------------------------------------------------
// Input side is a queue write port: present data_byte and end_of_text with
// push, and the byte is taken on a clock edge where full is low. Results come
// out of a queue read port: while empty is low, the oldest character of the
// current n-gram is on char_value, char_bytes, position_in_gram and
// last_of_gram, and pop takes it. gram_size is written through cfg_we and
// cfg_wdata; the user must write it only while the block is idle, which the
// block itself does not enforce; reset sets it to 3. The front end takes
// one byte per cycle while its four-entry character queue has room and no
// cut-off character is being replayed; a character cut off by end_of_text
// has its trailing bytes replayed while full is held high. The window logic
// takes no new character while it emits an n-gram. A character completing
// an n-gram passes through the queue, the ring and the output register before
// empty falls. When the receiver stalls, the output register holds, the window logic
// waits, the queue fills and then full rises. Reset clears the window, the
// queue and any partial character.
// ----------------------------------------------------------------------------
module utf8_char_ngram_window import ucng_pkg::*; #(
	parameter int MAX_GRAM = MAX_GRAM_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_wdata,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        end_of_text,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] char_value,
	output logic [2:0]  char_bytes,
	output logic [2:0]  position_in_gram,
	output logic        last_of_gram
);

	logic [3:0]  gram_size_q;
	logic        ent_push;
	char_entry_t ent;
	logic        q_full;
	logic        q_empty;
	logic        q_pop;
	char_entry_t q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gram_size_q <= GRAM_SIZE_RESET;
		end else if (cfg_we) begin
			gram_size_q <= cfg_wdata;
		end
	end

	ucng_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.data_byte   (data_byte),
		.end_of_text (end_of_text),
		.q_full      (q_full),
		.ent_push    (ent_push),
		.ent         (ent)
	);

	ucng_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (ent_push),
		.wr_data (ent),
		.q_full  (q_full),
		.rd_en   (q_pop),
		.rd_data (q_data),
		.q_empty (q_empty)
	);

	ucng_back #(
		.MAX_GRAM (MAX_GRAM)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.gram_size        (gram_size_q),
		.q_empty          (q_empty),
		.q_data           (q_data),
		.q_pop            (q_pop),
		.empty            (empty),
		.pop              (pop),
		.char_value       (char_value),
		.char_bytes       (char_bytes),
		.position_in_gram (position_in_gram),
		.last_of_gram     (last_of_gram)
	);

endmodule
